// ===== hw/rtl/rtu_frame_receiver_crc16_top_defines.svh =====
// Assertion macros used by the receive framer checker module.
`ifndef RTU_FRAME_RECEIVER_CRC16_TOP_DEFINES_SVH
`define RTU_FRAME_RECEIVER_CRC16_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define RTUFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RTUFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rtufr_pkg.sv =====
// Types, codes and the CRC-16 step of the RTU receive framer.
package rtufr_pkg;

    // beat kind on the slave side (tuser)
    localparam logic [1:0] FN_BYTE = 2'd0;
    localparam logic [1:0] FN_TICK = 2'd1;
    localparam logic [1:0] FN_EMIT = 2'd2;
    localparam logic [1:0] FN_READ = 2'd3;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_DELIVER = 2'd1;
    localparam logic [1:0] EV_DISCARD = 2'd2;

    localparam logic [2:0] LM_INITIAL   = 3'd0;
    localparam logic [2:0] LM_IDLE      = 3'd1;
    localparam logic [2:0] LM_RECEPTION = 3'd2;
    localparam logic [2:0] LM_CTRL_WAIT = 3'd3;
    localparam logic [2:0] LM_EMISSION  = 3'd4;

    localparam logic [1:0] REG_GAP_SHORT = 2'd0;
    localparam logic [1:0] REG_GAP_LONG  = 2'd1;

    localparam int unsigned SIL_W = 24;
    localparam logic [SIL_W-1:0] SIL_MAX         = 24'hFFFFFF;
    localparam logic [SIL_W-1:0] GAP_SHORT_RESET = 24'd4096;
    localparam logic [SIL_W-1:0] GAP_LONG_RESET  = 24'd9600;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [4:0] {
        M_INITIAL   = 5'b00001,
        M_IDLE      = 5'b00010,
        M_RECEPTION = 5'b00100,
        M_CTRL_WAIT = 5'b01000,
        M_EMISSION  = 5'b10000
    } t_mode;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        case (m)
            M_INITIAL:   c = LM_INITIAL;
            M_IDLE:      c = LM_IDLE;
            M_RECEPTION: c = LM_RECEPTION;
            M_CTRL_WAIT: c = LM_CTRL_WAIT;
            M_EMISSION:  c = LM_EMISSION;
            default:     c = LM_INITIAL;
        endcase
        return c;
    endfunction

    // reflected CRC-16, one byte
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/rtufr_bank_ram.sv =====
// Frame bank store: one write port, one registered read port.
module rtufr_bank_ram #(
    parameter int unsigned DEPTH = 512,
    parameter int unsigned AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== hw/rtl/rtu_frame_receiver_crc16_top.sv =====
// RTU receive framer with CRC-16 check and double-buffered frame banks.
//
// Slave stream: one beat per event. tuser selects the event: received byte,
// silence tick, emission begun, or read of a completed-frame byte. tdata
// carries the byte, the read index and the response-error flag.
// Master stream: exactly one result beat per slave beat, in order, with the
// frame event, delivered length, CRC verdict, read byte and line mode.
// Config channel: gap registers (short, long) written by index; always ready.
// The result of an accepted beat passes through the request stage, with the
// bank read in flight, and then the output register.
// Throughput: one beat per cycle while the master side does not stall; the
// bank read port is registered, the only multi-cycle path, fully pipelined.
// A stalled master side holds the output register; the slave side keeps
// taking beats until the request stage is also full, then drops tready.
// Reset puts the line in initial mode with the gaps at their defaults; the
// bank contents are not cleared, and only entries written by reception are
// ever read back meaningfully.
module rtu_frame_receiver_crc16_top #(
    parameter int unsigned FRAME_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // rx_byte[7:0], read_index[15:8], response_error[16]
    input  logic [1:0]  i_s_tuser,   // func[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // frame_event, frame_length, crc_good, read_data, line_mode (low bit up)
    output logic [((2 + $clog2(FRAME_BYTES + 1) + 12) + 7) / 8 * 8 - 1:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import rtufr_pkg::*;

    localparam int unsigned LEN_W  = $clog2(FRAME_BYTES + 1);
    localparam int unsigned AW     = $clog2(2 * FRAME_BYTES);
    localparam int unsigned RW     = (AW > 8) ? AW : 8;
    localparam int unsigned OUT_W  = 2 + LEN_W + 12;
    localparam int unsigned OUT_TW = (OUT_W + 7) / 8 * 8;

    logic [7:0] rx_byte;
    logic [7:0] read_index;
    logic       resp_err;
    logic [1:0] func;
    assign rx_byte    = i_s_tdata[7:0];
    assign read_index = i_s_tdata[15:8];
    assign resp_err   = i_s_tdata[16];
    assign func       = i_s_tuser;

    // configuration
    logic [SIL_W-1:0] r_gap_short, r_gap_long;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_short <= GAP_SHORT_RESET;
            r_gap_long  <= GAP_LONG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GAP_SHORT: r_gap_short <= i_cfg_data;
                REG_GAP_LONG:  r_gap_long  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // line state
    t_mode            r_mode, n_mode;
    logic [SIL_W-1:0] r_sil, n_sil;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic             r_ok, n_ok;
    logic [15:0]      r_crc, n_crc;
    logic             r_bank, n_bank;

    // pipeline
    logic             r_a_valid, r_a_rd;
    logic [1:0]       r_a_ev;
    logic [LEN_W-1:0] r_a_len;
    logic             r_a_crc;
    logic [2:0]       r_a_mode;
    logic             r_b_valid;
    logic [OUT_TW-1:0] r_b_data;

    logic a_move, acc;
    assign a_move     = r_a_valid && (!r_b_valid || i_m_tready);
    assign o_s_tready = !r_a_valid || a_move;
    assign acc        = i_s_tvalid && o_s_tready;

    logic [1:0]       ev;
    logic [LEN_W-1:0] flen;
    logic             fcrc;
    logic             wr_en, rd_en, rd_ok;
    logic [SIL_W-1:0] sil_inc;
    logic [LEN_W-1:0] base_idx;
    logic [15:0]      base_crc;
    logic             base_ok;
    logic             to_cw;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [RW-1:0]    rd_sum;
    logic [7:0]       mem_q;

    assign sil_inc  = (r_sil == SIL_MAX) ? r_sil : r_sil + 1'b1;
    assign base_idx = (r_mode == M_IDLE) ? '0 : r_idx;
    assign base_crc = (r_mode == M_IDLE) ? CRC_INIT : r_crc;
    assign base_ok  = (r_mode == M_IDLE) ? 1'b1 : r_ok;
    assign wr_addr  = AW'(base_idx) + (r_bank ? AW'(FRAME_BYTES) : '0);
    assign rd_sum   = RW'(read_index) + (r_bank ? RW'(0) : RW'(FRAME_BYTES));
    assign rd_addr  = rd_sum[AW-1:0];
    assign rd_ok    = 32'(read_index) < FRAME_BYTES;
    assign rd_en    = acc && (func == FN_READ);

    always_comb begin
        n_mode = r_mode;
        n_sil  = r_sil;
        n_idx  = r_idx;
        n_ok   = r_ok;
        n_crc  = r_crc;
        n_bank = r_bank;
        ev     = EV_NONE;
        flen   = '0;
        fcrc   = 1'b0;
        wr_en  = 1'b0;
        to_cw  = 1'b0;
        if (acc) begin
            case (func)
                FN_BYTE: begin
                    case (r_mode)
                        M_INITIAL: n_sil = '0;
                        M_IDLE, M_RECEPTION: begin
                            if (base_idx >= LEN_W'(FRAME_BYTES)) begin
                                n_ok = 1'b0;   // overflow: byte dropped
                            end else begin
                                n_ok  = base_ok;
                                wr_en = 1'b1;
                                n_idx = base_idx + 1'b1;
                                n_crc = crc_update(base_crc, rx_byte);
                            end
                            if (r_mode == M_IDLE && base_idx >= LEN_W'(FRAME_BYTES)) begin
                                n_ok = 1'b0;
                            end
                            n_sil  = '0;
                            n_mode = M_RECEPTION;
                        end
                        M_CTRL_WAIT: n_ok = 1'b0;
                        default: ;
                    endcase
                end
                FN_TICK: begin
                    n_sil = sil_inc;
                    case (r_mode)
                        M_INITIAL, M_EMISSION: begin
                            if (sil_inc >= r_gap_long) begin
                                n_mode = M_IDLE;
                                n_sil  = '0;
                            end
                        end
                        M_RECEPTION, M_CTRL_WAIT: begin
                            to_cw = (r_mode == M_CTRL_WAIT) || (sil_inc >= r_gap_short);
                            if (to_cw) begin
                                n_mode = M_CTRL_WAIT;
                            end
                            // short and long gap may both be reached on one tick
                            if (to_cw && sil_inc >= r_gap_long) begin
                                if (r_ok && !resp_err) begin
                                    n_bank = !r_bank;
                                    ev     = EV_DELIVER;
                                    flen   = r_idx;
                                    fcrc   = (r_idx >= LEN_W'(2)) && (r_crc == 16'h0000);
                                end else begin
                                    ev = EV_DISCARD;
                                end
                                n_ok   = 1'b1;
                                n_idx  = '0;
                                n_crc  = CRC_INIT;
                                n_sil  = '0;
                                n_mode = M_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
                FN_EMIT: begin
                    if (r_mode == M_IDLE) begin
                        n_mode = M_EMISSION;
                        n_sil  = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_INITIAL;
            r_sil  <= '0;
            r_idx  <= '0;
            r_ok   <= 1'b1;
            r_crc  <= CRC_INIT;
            r_bank <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_sil  <= n_sil;
            r_idx  <= n_idx;
            r_ok   <= n_ok;
            r_crc  <= n_crc;
            r_bank <= n_bank;
        end
    end

    rtufr_bank_ram #(
        .DEPTH (2 * FRAME_BYTES),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (rx_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (mem_q)
    );

    // request stage: waits for the bank read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (acc) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_ev   <= ev;
            r_a_len  <= flen;
            r_a_crc  <= fcrc;
            r_a_rd   <= (func == FN_READ) && rd_ok;
            r_a_mode <= mode_code(n_mode);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_move) begin
            r_b_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_data <= OUT_TW'({r_a_mode, (r_a_rd ? mem_q : 8'h00), r_a_crc, r_a_len, r_a_ev});
        end
    end

    assign o_m_tvalid = r_b_valid;
    assign o_m_tdata  = r_b_data;
endmodule

// ===== hw/rtl/rtufr_checker.sv =====
// Port-level checks on the receive framer, bound to the top level.
`include "rtu_frame_receiver_crc16_top_defines.svh"

module rtufr_checker #(
    parameter int unsigned FRAME_BYTES = 256
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_m_tvalid,
    input logic i_m_tready,
    input logic [((2 + $clog2(FRAME_BYTES + 1) + 12) + 7) / 8 * 8 - 1:0] i_m_tdata
);
    import rtufr_pkg::*;

    localparam int unsigned LEN_W = $clog2(FRAME_BYTES + 1);

    logic [1:0]       ev;
    logic [LEN_W-1:0] len;
    logic             crc_ok;
    logic [2:0]       lm;
    assign ev     = i_m_tdata[1:0];
    assign len    = i_m_tdata[LEN_W+1:2];
    assign crc_ok = i_m_tdata[LEN_W+2];
    assign lm     = i_m_tdata[LEN_W+13:LEN_W+11];

    `RTUFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata), "result beat changed while stalled")

    `RTUFR_ASSERT_NOW(a_len_only_on_delivery, i_clk, i_rst_n, i_m_tvalid && ev != EV_DELIVER, len == '0 && !crc_ok, "length or crc flag without a delivery")

    `RTUFR_ASSERT_NOW(a_close_goes_idle, i_clk, i_rst_n, i_m_tvalid && (ev == EV_DELIVER || ev == EV_DISCARD), lm == LM_IDLE, "frame closed but line not idle")

    `RTUFR_ASSERT_NOW(a_crc_needs_bytes, i_clk, i_rst_n, i_m_tvalid && crc_ok, len >= LEN_W'(2), "crc good on a frame shorter than two bytes")

endmodule

bind rtu_frame_receiver_crc16_top rtufr_checker #(
    .FRAME_BYTES (FRAME_BYTES)
) u_rtufr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

// ===== sim/rtufr_tb_pkg.sv =====
// Scoreboard for the RTU receive framer: line-state predictor and result checks.
package rtufr_tb_pkg;
    import rtufr_pkg::*;

    localparam int unsigned BANK_BYTES = 256;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
        logic       resp_err;
    } t_line_item;

    typedef struct packed {
        logic [1:0] ev;
        logic [8:0] length;
        logic       crc_ok;
        logic [7:0] read_data;
        logic [2:0] line_mode;
    } t_frame_result;

    class frame_scoreboard;
        logic [23:0]   gap_short;
        logic [23:0]   gap_long;
        logic [2:0]    mode;
        logic [23:0]   silence;
        logic [8:0]    fill;
        logic          frame_ok;
        logic [15:0]   crc;
        logic [7:0]    bank_mem [2*BANK_BYTES];
        bit            written [2*BANK_BYTES];
        logic          rx_bank;
        logic [8:0]    done_len;
        logic          done_good;
        t_frame_result pending_q [$];
        int            errors;

        function new();
            gap_short = GAP_SHORT_RESET;
            gap_long  = GAP_LONG_RESET;
            mode      = LM_INITIAL;
            silence   = '0;
            fill      = '0;
            frame_ok  = 1'b1;
            crc       = CRC_INIT;
            rx_bank   = 1'b0;
            done_len  = '0;
            done_good = 1'b0;
            errors    = 0;
            foreach (bank_mem[i]) begin
                bank_mem[i] = '0;
                written[i]  = 1'b0;
            end
        endfunction

        static function logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            return r;
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] val);
            case (idx)
                REG_GAP_SHORT: gap_short = val;
                REG_GAP_LONG:  gap_long  = val;
                default: ;
            endcase
        endfunction

        // true when the completed bank holds a received byte at idx
        function bit readable(logic [7:0] idx);
            return written[{~rx_bank, idx}];
        endfunction

        function void store_byte(logic [7:0] b);
            if (fill >= BANK_BYTES) begin
                frame_ok = 1'b0;   // overflow: byte dropped
                return;
            end
            bank_mem[{rx_bank, fill[7:0]}] = b;
            written[{rx_bank, fill[7:0]}]  = 1'b1;
            fill = fill + 1'b1;
            crc  = crc16_byte(crc, b);
        endfunction

        function void note_beat(t_line_item it);
            t_frame_result r;
            r = '0;
            case (it.func)
                FN_BYTE: begin
                    case (mode)
                        LM_INITIAL: silence = '0;
                        LM_IDLE: begin
                            fill     = '0;
                            frame_ok = 1'b1;
                            crc      = CRC_INIT;
                            store_byte(it.rx_byte);
                            silence  = '0;
                            mode     = LM_RECEPTION;
                        end
                        LM_RECEPTION: begin
                            store_byte(it.rx_byte);
                            silence = '0;
                        end
                        LM_CTRL_WAIT: frame_ok = 1'b0;
                        default: ;
                    endcase
                end
                FN_TICK: begin
                    if (silence != SIL_MAX) silence = silence + 1'b1;
                    if (mode == LM_INITIAL || mode == LM_EMISSION) begin
                        if (silence >= gap_long) begin
                            mode    = LM_IDLE;
                            silence = '0;
                        end
                    end else begin
                        if (mode == LM_RECEPTION && silence >= gap_short) mode = LM_CTRL_WAIT;
                        // short and long gap may both be reached on one tick
                        if (mode == LM_CTRL_WAIT && silence >= gap_long) begin
                            if (frame_ok && !it.resp_err) begin
                                rx_bank   = ~rx_bank;
                                done_len  = fill;
                                done_good = (fill >= 2) && (crc == 16'h0000);
                                r.ev      = EV_DELIVER;
                                r.length  = done_len;
                                r.crc_ok  = done_good;
                            end else begin
                                r.ev = EV_DISCARD;
                            end
                            frame_ok = 1'b1;
                            fill     = '0;
                            crc      = CRC_INIT;
                            silence  = '0;
                            mode     = LM_IDLE;
                        end
                    end
                end
                FN_EMIT: begin
                    if (mode == LM_IDLE) begin
                        mode    = LM_EMISSION;
                        silence = '0;
                    end
                end
                default: r.read_data = bank_mem[{~rx_bank, it.read_index}];
            endcase
            r.line_mode = mode;
            pending_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned due, int unsigned got,
                                    realtime now);
            if (due != got) begin
                $display("%0.1f ns: %s mismatch, expected %0d, actual %0d",
                         now, name, due, got);
                errors++;
            end
        endfunction

        function void check_result(logic [23:0] raw, realtime now);
            t_frame_result due;
            if (pending_q.size() == 0) begin
                $display("%0.1f ns: result %h with nothing expected, expected none, actual %h",
                         now, raw, raw);
                errors++;
                return;
            end
            due = pending_q.pop_front();
            compare_field("frame_event",  due.ev,        raw[1:0],   now);
            compare_field("frame_length", due.length,    raw[10:2],  now);
            compare_field("crc_good",     due.crc_ok,    raw[11],    now);
            compare_field("read_data",    due.read_data, raw[19:12], now);
            compare_field("line_mode",    due.line_mode, raw[22:20], now);
        endfunction
    endclass

endpackage

// ===== sim/tb_top.sv =====
// Testbench top for the RTU receive framer: stimulus, stream handshakes and run control.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rtufr_pkg::*;
    import rtufr_tb_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 950;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned N_PH         = 9;
    localparam logic [1:0]  REG_SPARE    = 2'd2;   // index with no register behind it

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;       // rx_byte[7:0], read_index[15:8], response_error[16]
    logic [1:0]  s_tuser  = FN_BYTE;  // func[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;             // frame_event, frame_length, crc_good, read_data, line_mode
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_GAP_SHORT;
    logic [23:0] cfg_data  = '0;

    frame_scoreboard sb;
    int unsigned     cycles    = 0;
    int unsigned     hold_cnt  = 0;
    int              burst_left = 0;
    int              items_sent = 0;
    logic            want_hold = 1'b0;
    logic            hold_seen = 1'b0;

    // gap settings per phase; an all-ones gap never elapses within the run
    logic [23:0] ph_short [N_PH] = '{24'd2, 24'd1, 24'd5, 24'd1, 24'd3,
                                     SIL_MAX, 24'd1, 24'd4, 24'd2};
    logic [23:0] ph_long  [N_PH] = '{24'd3, 24'd1, 24'd3, SIL_MAX, 24'd9,
                                     24'd2, 24'd2, 24'd16, 24'd3};

    rtu_frame_receiver_crc16_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: check each beat, then choose next tready
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata, $realtime);
        if (want_hold != hold_seen) begin
            hold_seen <= want_hold;
            hold_cnt  <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            case (cycles[9:8])
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= 1'($urandom_range(0, 1));
                2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    function automatic t_line_item mk_item(logic [1:0] f, logic [7:0] b, logic [7:0] idx,
                                           logic e);
        t_line_item it;
        it.func       = f;
        it.rx_byte    = b;
        it.read_index = idx;
        it.resp_err   = e;
        return it;
    endfunction

    // valid stays high within a burst; the next push follows in the same step
    task automatic push(input t_line_item it);
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {7'd0, it.resp_err, it.read_index, it.rx_byte};
        do @(posedge i_clk); while (!s_tready);
        sb.note_beat(it);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 20);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        push(mk_item(FN_BYTE, b, 8'($urandom), $urandom_range(0, 7) == 0));
    endtask

    task automatic tick(input logic e);
        push(mk_item(FN_TICK, 8'($urandom), 8'($urandom), e));
    endtask

    task automatic emit();
        push(mk_item(FN_EMIT, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1))));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_q.size() != 0);
    endtask

    task automatic set_gaps(input logic [23:0] short_g, input logic [23:0] long_g,
                            input bit poke_spare);
        logic [1:0]  idx [3];
        logic [23:0] val [3];
        int          n;
        idx = '{REG_GAP_SHORT, REG_GAP_LONG, REG_SPARE};
        val = '{short_g, long_g, 24'($urandom)};
        n = poke_spare ? 3 : 2;
        drain();
        cfg_valid <= 1'b1;
        for (int k = 0; k < n; k++) begin
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge i_clk); while (!cfg_ready);
            sb.write_reg(idx[k], val[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic settle_idle();
        while (sb.mode != LM_IDLE) tick($urandom_range(0, 5) == 0);
    endtask

    // reads only touch bank entries that reception has written
    task automatic read_some(input int n);
        logic [7:0] idx;
        bit         ok;
        repeat (n) begin
            idx = 8'($urandom);
            ok  = sb.readable(idx);
            if (!ok && sb.done_len != 0) begin
                idx = 8'($urandom_range(0, sb.done_len - 1));
                ok  = 1'b1;
            end
            if (ok) push(mk_item(FN_READ, 8'($urandom), idx, 1'($urandom_range(0, 1))));
        end
    endtask

    task automatic noise_item();
        int f;
        f = $urandom_range(0, 3);
        if (f == FN_READ) read_some(1);
        else push(mk_item(2'(f), 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1))));
    endtask

    task automatic send_frame(input logic [7:0] payload [$], input bit crc_right);
        logic [15:0] c;
        c = CRC_INIT;
        settle_idle();
        foreach (payload[i]) begin
            c = frame_scoreboard::crc16_byte(c, payload[i]);
            send_byte(payload[i]);
            if ($urandom_range(0, 15) == 0) noise_item();
        end
        if (crc_right) begin
            send_byte(c[7:0]);
            send_byte(c[15:8]);
        end else begin
            send_byte(8'($urandom));
            send_byte(8'($urandom));
        end
        settle_idle();
    endtask

    task automatic rand_frame(input int n, input bit crc_right);
        logic [7:0] pl [$];
        repeat (n) pl.push_back(8'($urandom));
        send_frame(pl, crc_right);
    endtask

    initial begin
        int unsigned base;
        int unsigned phase_end;
        int          dice;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // initial mode at reset gaps: bytes only restart the silence count and emission requests have no effect
        send_byte(8'hFF);
        tick(1'b1);
        push(mk_item(FN_EMIT, 8'h00, 8'hFF, 1'b0));
        set_gaps(24'd2, 24'd3, 1'b1);
        settle_idle();
        emit();
        send_byte(8'h00);
        settle_idle();
        send_frame('{8'h00, 8'hFF}, 1'b1);
        // the frame may have been dropped, so only read what the completed bank holds
        for (int i = 0; i < 4; i++) begin
            if (sb.readable(8'(i))) push(mk_item(FN_READ, 8'($urandom), 8'(i), 1'b0));
        end
        // byte arriving in control-wait spoils the frame
        send_byte(8'h5A);
        tick(1'b0);
        tick(1'b0);
        send_byte(8'hA5);
        tick(1'b0);
        // response error on the closing tick
        send_byte(8'h81);
        send_byte(8'h7E);
        repeat (3) tick(1'b1);
        // emission request during reception is ignored
        send_byte(8'h42);
        emit();
        settle_idle();

        base = items_sent;
        for (int p = 0; p < N_PH; p++) begin
            set_gaps(ph_short[p], ph_long[p], p == 4);
            if (ph_short[p] == SIL_MAX || ph_long[p] == SIL_MAX) begin
                repeat (15) noise_item();
                continue;
            end
            settle_idle();
            if (p == 0) begin
                rand_frame(254, 1'b1);   // fills the bank exactly
                if (sb.readable(8'h00)) push(mk_item(FN_READ, 8'h00, 8'h00, 1'b1));
                if (sb.readable(8'hFF)) push(mk_item(FN_READ, 8'hFF, 8'hFF, 1'b0));
            end
            if (p == 1) want_hold <= ~want_hold;
            if (p == 2) rand_frame(257, 1'b0);   // overflow
            phase_end = base + RANDOM_ITEMS * (p + 1) / N_PH;
            while (items_sent < phase_end) begin
                dice = $urandom_range(0, 15);
                case (dice)
                    8, 9:   read_some($urandom_range(1, 4));
                    10: begin
                        emit();
                        settle_idle();
                    end
                    11, 12: noise_item();
                    13:     repeat ($urandom_range(1, 4)) tick($urandom_range(0, 3) == 0);
                    14:     rand_frame($urandom_range(9, 20), $urandom_range(0, 3) != 0);
                    default: rand_frame($urandom_range(0, 8), $urandom_range(0, 3) != 0);
                endcase
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
